@@ src/blsd_pkg.sv @@
// ----------------------------------------------------------------------------
// blsd_pkg
// Shared types and constants for the binary load segment deframer.
// ----------------------------------------------------------------------------
package blsd_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int IDX_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    localparam logic [15:0] MARKER_WORD = 16'hFFFF;
    localparam logic [15:0] RUN_LO      = 16'h02E0;
    localparam logic [15:0] RUN_HI      = 16'h02E1;
    localparam logic [15:0] INIT_LO     = 16'h02E2;
    localparam logic [15:0] INIT_HI     = 16'h02E3;
    localparam logic [13:0] VEC_QUAD    = RUN_LO[15:2];

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_EOF  = 1'b1;

    localparam logic [1:0] RK_WRITE   = 2'd0;
    localparam logic [1:0] RK_SEGMENT = 2'd1;
    localparam logic [1:0] RK_DONE    = 2'd2;
    localparam logic [1:0] RK_FAILED  = 2'd3;

    localparam logic [1:0] CLS_PLAIN = 2'd0;
    localparam logic [1:0] CLS_RUN   = 2'd1;
    localparam logic [1:0] CLS_INIT  = 2'd2;

    localparam logic [1:0] ERR_END_BELOW = 2'd0;
    localparam logic [1:0] ERR_TRUNCATED = 2'd1;
    localparam logic [1:0] ERR_TABLE     = 2'd2;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] address;
        logic [7:0]  data;
        logic [15:0] segment_end;
        logic [1:0]  segment_class;
        logic        overlapping;
        logic        last_of_segment;
        logic        run_valid;
        logic [15:0] run_address;
        logic        init_valid;
        logic [15:0] init_address;
        logic [1:0]  error_code;
    } result_t;

    typedef struct packed {
        logic             start;
        logic [15:0]      seg_begin;
        logic [15:0]      seg_end;
        logic [CNT_W-1:0] count;
    } walk_req_t;

    typedef struct packed {
        logic done;
        logic overlap;
    } walk_rsp_t;

endpackage

@@ src/blsd_item_if.sv @@
// ----------------------------------------------------------------------------
// blsd_item_if
// Input channel: one file byte or end of file per request.
// ----------------------------------------------------------------------------
interface blsd_item_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] byte_value;

    modport source (output valid, output kind, output byte_value, input ready);
    modport sink   (input valid, input kind, input byte_value, output ready);
endinterface

@@ src/blsd_result_if.sv @@
// ----------------------------------------------------------------------------
// blsd_result_if
// Output channel: memory writes, segment records and end-of-load reports.
// ----------------------------------------------------------------------------
interface blsd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [15:0] address;
    logic [7:0]  data;
    logic [15:0] segment_end;
    logic [1:0]  segment_class;
    logic        overlapping;
    logic        last_of_segment;
    logic        run_valid;
    logic [15:0] run_address;
    logic        init_valid;
    logic [15:0] init_address;
    logic [1:0]  error_code;

    modport source (
        output valid, output result_kind, output address, output data,
        output segment_end, output segment_class, output overlapping,
        output last_of_segment, output run_valid, output run_address,
        output init_valid, output init_address, output error_code,
        input ready
    );
    modport sink (
        input valid, input result_kind, input address, input data,
        input segment_end, input segment_class, input overlapping,
        input last_of_segment, input run_valid, input run_address,
        input init_valid, input init_address, input error_code,
        output ready
    );
endinterface

@@ src/blsd_walk.sv @@
// ----------------------------------------------------------------------------
// blsd_walk
// Segment table and overlap walker: one range compare reused per entry.
// ----------------------------------------------------------------------------
module blsd_walk (
    input  logic                clk,
    input  logic                rst_n,
    input  blsd_pkg::walk_req_t req,
    output blsd_pkg::walk_rsp_t rsp
);
    import blsd_pkg::*;

    localparam logic [1:0] W_IDLE = 2'd0;
    localparam logic [1:0] W_SCAN = 2'd1;
    localparam logic [1:0] W_DONE = 2'd2;

    logic [1:0]       wstate_reg, wstate_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]      beg_reg, beg_next;
    logic [15:0]      end_reg, end_next;
    logic             hit_reg, hit_next;
    logic             rvalid_reg, rvalid_next;
    logic [31:0]      rdata_reg;
    logic [31:0]      seg_mem [MAX_SEGMENTS];

    logic             rd_en;
    logic             wr_en;
    logic             meet;

    assign rd_en = (wstate_reg == W_SCAN) && (idx_reg < cnt_reg);
    assign wr_en = (wstate_reg == W_DONE);
    assign meet  = rvalid_reg &&
                   !((end_reg < rdata_reg[15:0]) || (beg_reg > rdata_reg[31:16]));

    assign rsp.done    = wr_en;
    assign rsp.overlap = hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            seg_mem[cnt_reg[IDX_W-1:0]] <= {end_reg, beg_reg};
        end
        if (rd_en)
        begin
            rdata_reg <= seg_mem[idx_reg[IDX_W-1:0]];
        end
    end

    always_comb
    begin
        wstate_next = wstate_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        beg_next    = beg_reg;
        end_next    = end_reg;
        hit_next    = hit_reg | meet;
        rvalid_next = rd_en;
        unique case (wstate_reg)
            W_IDLE:
            begin
                if (req.start)
                begin
                    wstate_next = W_SCAN;
                    idx_next    = '0;
                    cnt_next    = req.count;
                    beg_next    = req.seg_begin;
                    end_next    = req.seg_end;
                    hit_next    = 1'b0;
                end
            end
            W_SCAN:
            begin
                if (rd_en)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                else
                begin
                    wstate_next = W_DONE;
                end
            end
            W_DONE:
            begin
                wstate_next = W_IDLE;
            end
            default:
            begin
                wstate_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wstate_reg <= W_IDLE;
            idx_reg    <= '0;
            cnt_reg    <= '0;
            hit_reg    <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            wstate_reg <= wstate_next;
            idx_reg    <= idx_next;
            cnt_reg    <= cnt_next;
            hit_reg    <= hit_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beg_reg <= beg_next;
        end_reg <= end_next;
    end

endmodule

@@ src/binary_load_segment_deframer.sv @@
// ----------------------------------------------------------------------------
// binary_load_segment_deframer
// Parses a segmented binary load file into segment records and memory writes.
// ----------------------------------------------------------------------------
// A file byte or end-of-file request is taken in one handshake. A data byte's
// memory write is presented on the next cycle, so data streams at one byte
// per cycle while the result side keeps up. The request that completes a
// segment header starts a walk over the segment table held in a single-port
// memory, unless the header fails its end or table check: one entry is read
// and range-compared per cycle, the header's record is registered when the
// walk ends, and no request is taken during the walk. A result that waits
// in the output register blocks every request until the result side takes
// it; a request can be taken in the same cycle that the waiting result
// leaves.
module binary_load_segment_deframer (
    input  logic          clk,
    input  logic          rst_n,
    blsd_item_if.sink     item,
    blsd_result_if.source result
);
    import blsd_pkg::*;

    localparam logic [2:0] PH_START_LO = 3'd0;
    localparam logic [2:0] PH_START_HI = 3'd1;
    localparam logic [2:0] PH_END_LO   = 3'd2;
    localparam logic [2:0] PH_END_HI   = 3'd3;
    localparam logic [2:0] PH_DATA     = 3'd4;
    localparam logic [2:0] PH_WALK     = 3'd5;

    logic [2:0]       phase_reg, phase_next;
    logic [7:0]       low_reg, low_next;
    logic [15:0]      start_reg, start_next;
    logic [15:0]      last_reg, last_next;
    logic [15:0]      wptr_reg, wptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [3:0][7:0]  vec_reg, vec_next;
    logic [3:0]       seen_reg, seen_next;
    logic             failed_reg, failed_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;
    logic             out_load;

    walk_req_t        walk_req;
    walk_rsp_t        walk_rsp;

    logic             item_ready;
    logic             in_fire;
    logic [15:0]      word;
    logic [1:0]       seg_class;

    blsd_walk u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (walk_req),
        .rsp   (walk_rsp)
    );

    assign item_ready = (phase_reg != PH_WALK) && (!out_valid_reg || result.ready);
    assign item.ready = item_ready;
    assign in_fire    = item.valid && item_ready;
    assign word       = {item.byte_value, low_reg};

    always_comb
    begin
        if (start_reg == RUN_LO && last_reg == RUN_HI)
        begin
            seg_class = CLS_RUN;
        end
        else if (start_reg == INIT_LO && last_reg == INIT_HI)
        begin
            seg_class = CLS_INIT;
        end
        else
        begin
            seg_class = CLS_PLAIN;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        low_next    = low_reg;
        start_next  = start_reg;
        last_next   = last_reg;
        wptr_next   = wptr_reg;
        count_next  = count_reg;
        vec_next    = vec_reg;
        seen_next   = seen_reg;
        failed_next = failed_reg;
        out_load    = 1'b0;
        out_next    = '0;
        walk_req    = '0;

        if (walk_rsp.done)
        begin
            // record goes out once the table walk settles the overlap flag
            out_load               = 1'b1;
            out_next.result_kind   = RK_SEGMENT;
            out_next.address       = start_reg;
            out_next.segment_end   = last_reg;
            out_next.segment_class = seg_class;
            out_next.overlapping   = walk_rsp.overlap;
            count_next             = count_reg + CNT_W'(1);
            wptr_next              = start_reg;
            phase_next             = PH_DATA;
        end
        else if (in_fire)
        begin
            if (item.kind == KIND_EOF)
            begin
                if (!failed_reg)
                begin
                    out_load = 1'b1;
                    if (phase_reg != PH_START_LO)
                    begin
                        out_next.result_kind = RK_FAILED;
                        out_next.error_code  = ERR_TRUNCATED;
                    end
                    else
                    begin
                        out_next.result_kind  = RK_DONE;
                        out_next.run_valid    = seen_reg[0] & seen_reg[1];
                        out_next.run_address  = {vec_reg[1], vec_reg[0]};
                        out_next.init_valid   = seen_reg[2] & seen_reg[3];
                        out_next.init_address = {vec_reg[3], vec_reg[2]};
                    end
                end
                // return to the idle state for the next file
                phase_next  = PH_START_LO;
                low_next    = '0;
                start_next  = '0;
                last_next   = '0;
                wptr_next   = '0;
                count_next  = '0;
                vec_next    = '0;
                seen_next   = '0;
                failed_next = 1'b0;
            end
            else if (!failed_reg)
            begin
                unique case (phase_reg)
                    PH_START_LO, PH_END_LO:
                    begin
                        low_next   = item.byte_value;
                        phase_next = phase_reg + 3'd1;
                    end
                    PH_START_HI:
                    begin
                        start_next = word;
                        phase_next = (word == MARKER_WORD) ? PH_START_LO : PH_END_LO;
                    end
                    PH_END_HI:
                    begin
                        last_next = word;
                        if (word < start_reg)
                        begin
                            out_load             = 1'b1;
                            out_next.result_kind = RK_FAILED;
                            out_next.error_code  = ERR_END_BELOW;
                            failed_next          = 1'b1;
                        end
                        else if (count_reg >= CNT_W'(MAX_SEGMENTS))
                        begin
                            out_load             = 1'b1;
                            out_next.result_kind = RK_FAILED;
                            out_next.error_code  = ERR_TABLE;
                            failed_next          = 1'b1;
                        end
                        else
                        begin
                            walk_req.start     = 1'b1;
                            walk_req.seg_begin = start_reg;
                            walk_req.seg_end   = word;
                            walk_req.count     = count_reg;
                            phase_next         = PH_WALK;
                        end
                    end
                    PH_DATA:
                    begin
                        if (wptr_reg[15:2] == VEC_QUAD)
                        begin
                            vec_next[wptr_reg[1:0]]  = item.byte_value;
                            seen_next[wptr_reg[1:0]] = 1'b1;
                        end
                        out_load                 = 1'b1;
                        out_next.result_kind     = RK_WRITE;
                        out_next.address         = wptr_reg;
                        out_next.data            = item.byte_value;
                        out_next.last_of_segment = (wptr_reg == last_reg);
                        if (wptr_reg == last_reg)
                        begin
                            phase_next = PH_START_LO;
                        end
                        else
                        begin
                            wptr_next = wptr_reg + 16'd1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_START_LO;
                    end
                endcase
            end
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START_LO;
            low_reg       <= '0;
            start_reg     <= '0;
            last_reg      <= '0;
            wptr_reg      <= '0;
            count_reg     <= '0;
            vec_reg       <= '0;
            seen_reg      <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            low_reg       <= low_next;
            start_reg     <= start_next;
            last_reg      <= last_next;
            wptr_reg      <= wptr_next;
            count_reg     <= count_next;
            vec_reg       <= vec_next;
            seen_reg      <= seen_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.result_kind     = out_reg.result_kind;
    assign result.address         = out_reg.address;
    assign result.data            = out_reg.data;
    assign result.segment_end     = out_reg.segment_end;
    assign result.segment_class   = out_reg.segment_class;
    assign result.overlapping     = out_reg.overlapping;
    assign result.last_of_segment = out_reg.last_of_segment;
    assign result.run_valid       = out_reg.run_valid;
    assign result.run_address     = out_reg.run_address;
    assign result.init_valid      = out_reg.init_valid;
    assign result.init_address    = out_reg.init_address;
    assign result.error_code      = out_reg.error_code;

endmodule

@@ tb/tb_binary_load_segment_deframer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_load_segment_deframer
// Drives segmented load files byte by byte, with random gaps and stalls on
// both channels, and checks every result against a predictor of the parser.
// ----------------------------------------------------------------------------
module tb_binary_load_segment_deframer;
    import blsd_pkg::*;

    localparam int RUN_LIMIT     = 2_000_000;
    localparam int SETTLE_CYCLES = MAX_SEGMENTS + 40;
    localparam int RANDOM_ITEMS  = 120;
    localparam int HOLD_CYCLES   = 300;

    typedef enum logic [2:0] {
        PH_START_LO,
        PH_START_HI,
        PH_END_LO,
        PH_END_HI,
        PH_DATA
    } parse_phase_e;

    // Tracks the parser state and holds the results still owed by the block.
    class deframe_tracker;
        parse_phase_e phase;
        logic [7:0]   low_hold;
        logic [15:0]  seg_begin;
        logic [15:0]  seg_last;
        logic [15:0]  wr_addr;
        logic [15:0]  tbl_begin [MAX_SEGMENTS];
        logic [15:0]  tbl_end [MAX_SEGMENTS];
        int unsigned  seg_count;
        logic [7:0]   vec_bytes [4];
        logic [3:0]   vec_seen;
        bit           failed;
        result_t      awaited_results [$];
        int unsigned  mismatches;
        int unsigned  results_seen;

        function new();
            mismatches   = 0;
            results_seen = 0;
            restart();
        endfunction

        function void restart();
            phase     = PH_START_LO;
            low_hold  = '0;
            seg_begin = '0;
            seg_last  = '0;
            wr_addr   = '0;
            seg_count = 0;
            foreach (vec_bytes[i])
                vec_bytes[i] = '0;
            vec_seen  = '0;
            failed    = 1'b0;
        endfunction

        function void load_failed(logic [1:0] code);
            result_t r;
            r             = '0;
            r.result_kind = RK_FAILED;
            r.error_code  = code;
            awaited_results.push_back(r);
            failed = 1'b1;
        endfunction

        function void note_request(logic k, logic [7:0] b);
            result_t r;
            logic    hit;
            r   = '0;
            hit = 1'b0;
            if (k == KIND_EOF) begin
                if (failed) begin
                    // a failed load ends silently
                end else if (phase != PH_START_LO) begin
                    load_failed(ERR_TRUNCATED);
                end else begin
                    r.result_kind  = RK_DONE;
                    r.run_valid    = vec_seen[0] & vec_seen[1];
                    r.run_address  = {vec_bytes[1], vec_bytes[0]};
                    r.init_valid   = vec_seen[2] & vec_seen[3];
                    r.init_address = {vec_bytes[3], vec_bytes[2]};
                    awaited_results.push_back(r);
                end
                restart();
            end else if (!failed) begin
                case (phase)
                    PH_START_LO: begin
                        low_hold = b;
                        phase    = PH_START_HI;
                    end
                    PH_START_HI: begin
                        seg_begin = {b, low_hold};
                        // drop marker words
                        if (seg_begin == MARKER_WORD)
                            phase = PH_START_LO;
                        else
                            phase = PH_END_LO;
                    end
                    PH_END_LO: begin
                        low_hold = b;
                        phase    = PH_END_HI;
                    end
                    PH_END_HI: begin
                        seg_last = {b, low_hold};
                        if (seg_last < seg_begin) begin
                            load_failed(ERR_END_BELOW);
                        end else if (seg_count >= MAX_SEGMENTS) begin
                            load_failed(ERR_TABLE);
                        end else begin
                            for (int i = 0; i < seg_count; i++)
                                if (!(seg_last < tbl_begin[i] || seg_begin > tbl_end[i]))
                                    hit = 1'b1;
                            r.result_kind = RK_SEGMENT;
                            r.address     = seg_begin;
                            r.segment_end = seg_last;
                            if (seg_begin == RUN_LO && seg_last == RUN_HI)
                                r.segment_class = CLS_RUN;
                            else if (seg_begin == INIT_LO && seg_last == INIT_HI)
                                r.segment_class = CLS_INIT;
                            else
                                r.segment_class = CLS_PLAIN;
                            r.overlapping        = hit;
                            tbl_begin[seg_count] = seg_begin;
                            tbl_end[seg_count]   = seg_last;
                            seg_count++;
                            wr_addr = seg_begin;
                            phase   = PH_DATA;
                            awaited_results.push_back(r);
                        end
                    end
                    default: begin
                        if (wr_addr >= RUN_LO && wr_addr <= INIT_HI) begin
                            vec_bytes[wr_addr[1:0]] = b;
                            vec_seen[wr_addr[1:0]]  = 1'b1;
                        end
                        r.result_kind     = RK_WRITE;
                        r.address         = wr_addr;
                        r.data            = b;
                        r.last_of_segment = (wr_addr == seg_last);
                        awaited_results.push_back(r);
                        // hold the pointer on the last byte so it never wraps
                        if (wr_addr == seg_last)
                            phase = PH_START_LO;
                        else
                            wr_addr = wr_addr + 16'd1;
                    end
                endcase
            end
        endfunction

        task report_mismatch(string what);
            if (mismatches < 100)
                $display("mismatch at result %0d: %s", results_seen, what);
            mismatches++;
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %h, want %h", name, got, want));
        endtask

        task check_result(result_t got);
            result_t want;
            results_seen++;
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result, kind %0d address %h",
                                          got.result_kind, got.address));
                return;
            end
            want = awaited_results.pop_front();
            compare_field("result_kind", 16'(got.result_kind), 16'(want.result_kind));
            compare_field("address", got.address, want.address);
            compare_field("data", 16'(got.data), 16'(want.data));
            compare_field("segment_end", got.segment_end, want.segment_end);
            compare_field("segment_class", 16'(got.segment_class),
                          16'(want.segment_class));
            compare_field("overlapping", 16'(got.overlapping), 16'(want.overlapping));
            compare_field("last_of_segment", 16'(got.last_of_segment),
                          16'(want.last_of_segment));
            compare_field("run_valid", 16'(got.run_valid), 16'(want.run_valid));
            compare_field("run_address", got.run_address, want.run_address);
            compare_field("init_valid", 16'(got.init_valid), 16'(want.init_valid));
            compare_field("init_address", got.init_address, want.init_address);
            compare_field("error_code", 16'(got.error_code), 16'(want.error_code));
        endtask

        task finish_check();
            if (awaited_results.size() != 0)
                report_mismatch($sformatf("%0d results never arrived",
                                          awaited_results.size()));
        endtask
    endclass

    logic clk;
    logic rst_n;

    blsd_item_if   item_bus ();
    blsd_result_if result_bus ();

    binary_load_segment_deframer u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus)
    );

    deframe_tracker tracker;
    bit             tx_gaps;
    bit             rx_gaps;
    bit             hold_req;
    int             hold_left;
    int             rx_gap_left;
    int unsigned    file_items;
    int unsigned    cycle_count;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: long hold-off on request, otherwise random stall bursts.
    always @(negedge clk)
    begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            result_bus.ready <= 1'b0;
            hold_left--;
        end else if (rx_gap_left > 0) begin
            result_bus.ready <= 1'b0;
            rx_gap_left--;
        end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
            result_bus.ready <= 1'b0;
            rx_gap_left = $urandom_range(1, 17) - 1;
        end else begin
            result_bus.ready <= 1'b1;
        end
    end

    // Note accepted requests before checking results of the same edge.
    always @(posedge clk)
    begin : monitor
        result_t got;
        if (rst_n) begin
            if (item_bus.valid && item_bus.ready)
                tracker.note_request(item_bus.kind, item_bus.byte_value);
            if (result_bus.valid && result_bus.ready) begin
                got.result_kind     = result_bus.result_kind;
                got.address         = result_bus.address;
                got.data            = result_bus.data;
                got.segment_end     = result_bus.segment_end;
                got.segment_class   = result_bus.segment_class;
                got.overlapping     = result_bus.overlapping;
                got.last_of_segment = result_bus.last_of_segment;
                got.run_valid       = result_bus.run_valid;
                got.run_address     = result_bus.run_address;
                got.init_valid      = result_bus.init_valid;
                got.init_address    = result_bus.init_address;
                got.error_code      = result_bus.error_code;
                tracker.check_result(got);
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic k, input logic [7:0] b);
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            item_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        item_bus.valid      <= 1'b1;
        item_bus.kind       <= k;
        item_bus.byte_value <= b;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        file_items++;
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(KIND_BYTE, b);
    endtask

    task automatic send_eof();
        send_item(KIND_EOF, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_word(input logic [15:0] w);
        send_byte(w[7:0]);
        send_byte(w[15:8]);
    endtask

    task automatic send_segment(input logic [15:0] first, input logic [15:0] last);
        send_word(first);
        send_word(last);
        for (int a = first; a <= last; a++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // Pick a short segment, often near the vectors, the bottom or the top of memory.
    task automatic random_segment();
        int first;
        int len;
        len = $urandom_range(1, 8);
        case ($urandom_range(0, 5))
            0: first = RUN_LO - 3 + $urandom_range(0, 6);
            1: first = $urandom_range(0, 16'h0040);
            2: first = 16'hFFF0 + $urandom_range(0, 14);
            3: first = $urandom_range(0, 16'hFFFE);
            4: begin
                first = RUN_LO;
                len   = 2;
            end
            default: begin
                first = INIT_LO;
                len   = 2;
            end
        endcase
        if (first + len - 1 > 16'hFFFF)
            send_segment(16'(first), 16'hFFFF);
        else
            send_segment(16'(first), 16'(first + len - 1));
    endtask

    task automatic random_file();
        int          nseg;
        int          first;
        int          len;
        case ($urandom_range(0, 9))
            7: begin
                // cut the file inside a header or inside data
                if ($urandom_range(0, 1) == 1)
                    random_segment();
                first = $urandom_range(0, 16'hFFF0);
                len   = $urandom_range(2, 8);
                case ($urandom_range(0, 3))
                    0: send_byte(8'(first));
                    1: send_word(16'(first));
                    2: begin
                        send_word(16'(first));
                        send_byte(8'(first + len - 1));
                    end
                    default: begin
                        send_word(16'(first));
                        send_word(16'(first + len - 1));
                        repeat ($urandom_range(0, len - 1))
                            send_byte(8'($urandom_range(0, 255)));
                    end
                endcase
                send_eof();
            end
            8: begin
                first = $urandom_range(1, 16'hFFFE);
                send_word(16'(first));
                send_word(16'($urandom_range(0, first - 1)));
                repeat ($urandom_range(0, 5))
                    send_byte(8'($urandom_range(0, 255)));
                send_eof();
            end
            9: begin
                repeat ($urandom_range(0, 12))
                    send_byte(8'($urandom_range(0, 255)));
                send_eof();
            end
            default: begin
                nseg = $urandom_range(0, 5);
                repeat (nseg) begin
                    repeat ($urandom_range(0, 4) == 0 ? $urandom_range(1, 2) : 0)
                        send_word(MARKER_WORD);
                    random_segment();
                end
                if ($urandom_range(0, 3) == 0)
                    send_word(MARKER_WORD);
                send_eof();
            end
        endcase
    endtask

    task automatic wait_drained();
        item_bus.valid <= 1'b0;
        do
            @(negedge clk);
        while (tracker.awaited_results.size() != 0);
    endtask

    initial
    begin
        item_bus.valid      = 1'b0;
        item_bus.kind       = KIND_BYTE;
        item_bus.byte_value = 8'h00;
        result_bus.ready    = 1'b0;
        rst_n               = 1'b0;
        tx_gaps             = 1'b1;
        rx_gaps             = 1'b1;
        hold_req            = 1'b0;
        hold_left           = 0;
        rx_gap_left         = 0;
        file_items          = 0;
        tracker             = new();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // marker, both vector segments with extreme bytes, clean end
        send_word(MARKER_WORD);
        send_word(RUN_LO);
        send_word(RUN_HI);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_word(INIT_LO);
        send_word(INIT_HI);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_eof();

        // lowest segment, then end below start, ignored byte, silent end
        send_word(16'h0000);
        send_word(16'h0000);
        send_byte(8'hA5);
        send_word(16'hFFFE);
        send_word(16'h0001);
        send_byte(8'h5A);
        send_eof();

        // hold the result side while a segment streams in
        hold_req = 1'b1;
        send_segment(16'h1000, 16'h100F);
        send_eof();
        wait_drained();

        while (file_items < RANDOM_ITEMS) begin
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            random_file();
        end

        // fill the segment table, then one header too many
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
            first_seg : begin
                int f;
                f = $urandom_range(0, 16'h0080);
                send_segment(16'(f), 16'(f));
            end
        end
        send_word(16'h4000);
        send_word(16'h4001);
        send_byte(8'h77);
        send_eof();

        // last part without idling: a segment that ends at the top address
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        wait_drained();
        repeat (17) @(negedge clk);
        send_segment(16'hFFF8, 16'hFFFF);
        send_eof();
        random_file();

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        tracker.finish_check();
        if (tracker.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
